// ===== hw/rtl/cfp_pkg.sv =====
// Package for the command frame packer: framing constants, byte slots and shared types.
package cfp_pkg;

  // Fixed frame bytes and length constants.
  localparam logic [7:0] HEAD_HI   = 8'h55;
  localparam logic [7:0] HEAD_LO   = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'hF0;
  localparam logic [3:0] LEN_MASK  = 4'hF;
  localparam logic [7:0] LEN_EXTRA = 8'd2;

  // Default depth of the job queue between front and back.
  localparam int CFP_QUEUE_DEPTH = 4;

  // Position of a byte within the emitted sequence of one job.
  typedef enum logic [2:0] {
    SLOT_HEAD_HI = 3'd0,
    SLOT_HEAD_LO = 3'd1,
    SLOT_ADDR    = 3'd2,
    SLOT_LEN     = 3'd3,
    SLOT_CMD0    = 3'd4,
    SLOT_DATA    = 3'd5,
    SLOT_XOR     = 3'd6,
    SLOT_TAIL    = 3'd7
  } slot_t;

  // Front-end framing state.
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_WAIT_CMD1,
    FR_PAYLOAD
  } frame_state_t;

  // One unit of work for the back end: a header burst or a single payload byte.
  typedef struct packed {
    logic       header;
    logic [7:0] addr;
    logic [7:0] len;
    logic [7:0] cmd0;
    logic [7:0] data;
    logic [7:0] xsum;
    logic       trailer;
  } job_t;

  // Job write request from the front end into the queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

// ===== hw/rtl/cfp_if.sv =====
// Stream interfaces for the command input channel and the framed byte output channel.
interface cfp_in_if;
  import cfp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       frame_start;
  logic [7:0] module_addr;

  modport source (output valid, output cmd_byte, output frame_start, output module_addr,
                  input ready);
  modport sink   (input valid, input cmd_byte, input frame_start, input module_addr,
                  output ready);
endinterface

interface cfp_out_if;
  import cfp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output tx_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input tx_byte, input run_last, input frame_end,
                  output ready);
endinterface

// ===== hw/rtl/cfp_front.sv =====
// Front end: tracks frame position, accumulates the checksum and issues jobs.
module cfp_front
  import cfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] cmd_byte,
  input  logic       frame_start,
  input  logic [7:0] module_addr,
  output push_t      push
);

  frame_state_t state_r, state_nxt;
  logic [7:0]   held_first_r, held_first_nxt;
  logic [7:0]   held_addr_r, held_addr_nxt;
  logic [7:0]   xsum_r, xsum_nxt;
  logic [3:0]   count_r, count_nxt;
  logic [3:0]   taken_r, taken_nxt;

  logic [3:0]   nibble;
  logic [7:0]   len_byte;
  logic [7:0]   hdr_xsum;
  logic [7:0]   pay_xsum;
  logic         last_payload;

  // Values derived from the incoming byte.
  assign nibble       = cmd_byte[3:0] & LEN_MASK;
  assign len_byte     = {4'd0, nibble} + LEN_EXTRA;
  assign hdr_xsum     = held_addr_r ^ len_byte ^ held_first_r ^ cmd_byte;
  assign pay_xsum     = xsum_r ^ cmd_byte;
  assign last_payload = (taken_r + 4'd1) == count_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      if (frame_start) begin
        state_nxt = FR_WAIT_CMD1;
      end else begin
        unique case (state_r)
          FR_IDLE:      state_nxt = FR_IDLE;
          FR_WAIT_CMD1: state_nxt = (nibble == 4'd0) ? FR_IDLE : FR_PAYLOAD;
          FR_PAYLOAD:   state_nxt = last_payload ? FR_IDLE : FR_PAYLOAD;
          default:      state_nxt = FR_IDLE;
        endcase
      end
    end
  end

  // Output and datapath logic.
  always_comb begin
    held_first_nxt = held_first_r;
    held_addr_nxt  = held_addr_r;
    xsum_nxt       = xsum_r;
    count_nxt      = count_r;
    taken_nxt      = taken_r;
    push.valid     = 1'b0;
    push.job       = '{header: 1'b0, addr: held_addr_r, len: len_byte, cmd0: held_first_r,
                       data: cmd_byte, xsum: pay_xsum, trailer: 1'b0};
    if (accept) begin
      if (frame_start) begin
        held_first_nxt = cmd_byte;
        held_addr_nxt  = module_addr;
        xsum_nxt       = 8'd0;
        count_nxt      = 4'd0;
      end else begin
        unique case (state_r)
          FR_IDLE: begin
          end
          FR_WAIT_CMD1: begin
            push.valid       = 1'b1;
            push.job.header  = 1'b1;
            push.job.xsum    = hdr_xsum;
            push.job.trailer = (nibble == 4'd0);
            xsum_nxt         = hdr_xsum;
            count_nxt        = nibble;
            taken_nxt        = 4'd0;
          end
          FR_PAYLOAD: begin
            push.valid       = 1'b1;
            push.job.trailer = last_payload;
            xsum_nxt         = pay_xsum;
            taken_nxt        = taken_r + 4'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame contents; only read after a frame start has loaded them.
  always_ff @(posedge clk) begin
    held_first_r <= held_first_nxt;
    held_addr_r  <= held_addr_nxt;
    xsum_r       <= xsum_nxt;
    count_r      <= count_nxt;
    taken_r      <= taken_nxt;
  end

endmodule

// ===== hw/rtl/cfp_job_fifo.sv =====
// Short job queue that decouples the front end from the byte sequencer.
module cfp_job_fifo
  import cfp_pkg::*;
#(
  parameter int DEPTH = CFP_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output job_t  head,
  output logic  head_valid,
  output logic  full
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [IW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

// ===== hw/rtl/cfp_back.sv =====
// Back end: walks each queued job slot by slot and drives the registered byte output.
module cfp_back
  import cfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic       run_last,
  output logic       frame_end
);

  logic       started_r, started_nxt;
  slot_t      slot_r, slot_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       tail_r, tail_nxt;

  slot_t      slot;
  slot_t      final_slot;
  logic       advance;
  logic       emit;

  // The output register may load when empty or while its contents are taken.
  assign advance    = !valid_r || out_ready;
  assign emit       = advance && head_valid;
  assign slot       = started_r ? slot_r : (head.header ? SLOT_HEAD_HI : SLOT_DATA);
  assign final_slot = head.trailer ? SLOT_TAIL : SLOT_DATA;
  assign pop        = emit && (slot == final_slot);

  // Byte selection for the current slot.
  always_comb begin
    unique case (slot)
      SLOT_HEAD_HI: byte_nxt = HEAD_HI;
      SLOT_HEAD_LO: byte_nxt = HEAD_LO;
      SLOT_ADDR:    byte_nxt = head.addr;
      SLOT_LEN:     byte_nxt = head.len;
      SLOT_CMD0:    byte_nxt = head.cmd0;
      SLOT_DATA:    byte_nxt = head.data;
      SLOT_XOR:     byte_nxt = head.xsum;
      SLOT_TAIL:    byte_nxt = TAIL_BYTE;
      default:      byte_nxt = head.data;
    endcase
  end

  // Sequencer and output register update.
  always_comb begin
    started_nxt = started_r;
    slot_nxt    = slot_r;
    valid_nxt   = valid_r;
    last_nxt    = (slot == final_slot);
    tail_nxt    = (slot == SLOT_TAIL);
    if (advance) begin
      valid_nxt = head_valid;
    end
    if (emit) begin
      if (pop) begin
        started_nxt = 1'b0;
      end else begin
        started_nxt = 1'b1;
        slot_nxt    = slot_t'(slot + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      started_r <= started_nxt;
      valid_r   <= valid_nxt;
    end
  end

  // Payload registers hold while the receiver stalls.
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (emit) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      tail_r <= tail_nxt;
    end
  end

  assign out_valid = valid_r;
  assign tx_byte   = byte_r;
  assign run_last  = last_r;
  assign frame_end = tail_r;

endmodule

// ===== hw/rtl/command_frame_packer.sv =====
// Top level of the command frame packer: front end, job queue and byte sequencer.
//
// Usage: commands arrive on in_ch one byte per transaction. A transaction with
// frame_start high carries the first command byte and the module address; it is
// held and produces no output. The second byte releases a burst of six bytes
// (0x55, 0xAA, address, count plus 2, first byte, second byte), or eight when
// the payload count is zero, since checksum and 0xF0 tail then follow at once.
// Each payload byte gives one output byte; the last one also gives checksum and
// tail. Bytes with no frame open are dropped. out_ch carries one framed byte per
// transaction, with run_last on the final byte caused by an input transaction
// and frame_end on the tail.
// Throughput: one output byte per cycle from the sequencer while the receiver is
// ready, so payload bytes then pass at one per cycle; during a header burst the
// job queue (QUEUE_DEPTH entries) keeps accepting input until it fills.
// Bytes pass through the job queue and then the registered output.
// Reset clears the framing state, the queue and the output valid flag. When the
// receiver stalls, the output byte holds and in_ch.ready falls once the queue
// is full.
module command_frame_packer
  import cfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = CFP_QUEUE_DEPTH
) (
  input logic         clk,
  input logic         rst_n,
  cfp_in_if.sink      in_ch,
  cfp_out_if.source   out_ch
);

  push_t push;
  job_t  head;
  logic  head_valid;
  logic  pop;
  logic  full;
  logic  accept;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  cfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd_byte    (in_ch.cmd_byte),
    .frame_start (in_ch.frame_start),
    .module_addr (in_ch.module_addr),
    .push        (push)
  );

  cfp_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  cfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .tx_byte    (out_ch.tx_byte),
    .run_last   (out_ch.run_last),
    .frame_end  (out_ch.frame_end)
  );

endmodule

// ===== tb/cfp_frame_checker.sv =====
// Checker for the command frame packer: predicts the framed byte stream and compares it.
`timescale 1ns / 100ps

module cfp_frame_checker
  import cfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_cmd_byte,
  input  logic       in_frame_start,
  input  logic [7:0] in_module_addr,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_tx_byte,
  input  logic       out_run_last,
  input  logic       out_frame_end,
  output int         fail_count,
  output int         pending
);

  // One byte of the framed stream together with its flags.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
    logic       frame_end;
  } framed_byte_t;

  framed_byte_t tx_expected[$];

  // Predicted framing state.
  frame_state_t frame_st;
  logic [4:0]   payload_taken;
  logic [7:0]   first_byte;
  logic [7:0]   addr_latch;
  logic [7:0]   xsum;
  logic [3:0]   payload_len;

  task automatic push_byte(input logic [7:0] b, input logic tail);
    framed_byte_t fb;
    fb.tx_byte   = b;
    fb.run_last  = 1'b0;
    fb.frame_end = tail;
    tx_expected.push_back(fb);
  endtask

  // Checksum and tail close the frame and return the packer to idle.
  task automatic close_frame();
    push_byte(xsum, 1'b0);
    push_byte(TAIL_BYTE, 1'b1);
    frame_st = FR_IDLE;
  endtask

  // Works out the framed bytes that one accepted command byte releases.
  task automatic pack_command_byte(input logic [7:0] b, input logic st,
                                   input logic [7:0] a);
    logic [7:0] len_byte;
    int         before_cnt;
    before_cnt = tx_expected.size();
    if (st) begin
      first_byte    = b;
      addr_latch    = a;
      xsum          = 8'h00;
      payload_len   = 4'h0;
      payload_taken = 5'd0;
      frame_st      = FR_WAIT_CMD1;
    end else if (frame_st == FR_WAIT_CMD1) begin
      // Second byte: the whole header and both command bytes go out.
      payload_len   = b[3:0] & LEN_MASK;
      len_byte      = {4'h0, payload_len} + LEN_EXTRA;
      xsum          = addr_latch ^ len_byte ^ first_byte ^ b;
      push_byte(HEAD_HI, 1'b0);
      push_byte(HEAD_LO, 1'b0);
      push_byte(addr_latch, 1'b0);
      push_byte(len_byte, 1'b0);
      push_byte(first_byte, 1'b0);
      push_byte(b, 1'b0);
      payload_taken = 5'd0;
      frame_st      = FR_PAYLOAD;
      if (payload_len == 4'h0) close_frame();
    end else if (frame_st == FR_PAYLOAD) begin
      xsum          = xsum ^ b;
      push_byte(b, 1'b0);
      payload_taken = payload_taken + 5'd1;
      if (payload_taken >= {1'b0, payload_len}) close_frame();
    end
    // Flag the final byte of this transaction, if it produced any.
    if (tx_expected.size() > before_cnt)
      tx_expected[tx_expected.size() - 1].run_last = 1'b1;
  endtask

  // Observe both channels at each rising edge.
  always @(posedge clk) begin
    framed_byte_t want;
    if (!rst_n) begin
      frame_st      = FR_IDLE;
      payload_taken = 5'd0;
      first_byte    = 8'h00;
      addr_latch    = 8'h00;
      xsum          = 8'h00;
      payload_len   = 4'h0;
      fail_count    = 0;
      tx_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (tx_expected.size() == 0) begin
          $error("unexpected output byte: tx_byte %h run_last %b frame_end %b",
                 out_tx_byte, out_run_last, out_frame_end);
          fail_count++;
        end else begin
          want = tx_expected.pop_front();
          if (out_tx_byte !== want.tx_byte) begin
            $error("tx_byte mismatch: expected %h, actual %h", want.tx_byte, out_tx_byte);
            fail_count++;
          end
          if (out_run_last !== want.run_last) begin
            $error("run_last mismatch: expected %b, actual %b", want.run_last, out_run_last);
            fail_count++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %b, actual %b",
                   want.frame_end, out_frame_end);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        pack_command_byte(in_cmd_byte, in_frame_start, in_module_addr);
    end
    pending = tx_expected.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the command frame packer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int LONG_HOLD   = 120;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 10;
  localparam int FRAME_ITEMS = 250;
  localparam int CALM_ITEMS  = 210;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   calm;
  bit   hold_off_req;
  int   in_idle_pct;

  cfp_in_if  in_ch();
  cfp_out_if out_ch();

  command_frame_packer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cfp_frame_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_cmd_byte    (in_ch.cmd_byte),
    .in_frame_start (in_ch.frame_start),
    .in_module_addr (in_ch.module_addr),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_tx_byte    (out_ch.tx_byte),
    .out_run_last   (out_ch.run_last),
    .out_frame_end  (out_ch.frame_end),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one command byte, with an occasional idle burst before it, and waits
  // until the transaction is accepted.
  task automatic offer_byte(input logic [7:0] b, input logic st, input logic [7:0] a);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd_byte    <= b;
    in_ch.frame_start <= st;
    in_ch.module_addr <= a;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Receiver: random stall bursts, one long hold-off, none once the run is calm.
  initial begin : receiver
    int stall_left;
    int rate_left;
    int out_idle_pct;
    bit hold_done;
    stall_left   = 0;
    rate_left    = 0;
    out_idle_pct = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rate_left == 0) begin
        rate_left = 64;
        case ($urandom_range(0, 2))
          0:       out_idle_pct = 0;
          1:       out_idle_pct = 10;
          default: out_idle_pct = 35;
        endcase
      end
      rate_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req && !hold_done) begin
        hold_done    = 1'b1;
        stall_left   = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
        stall_left   = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction is accepted for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("command_frame_packer verification failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int         frame_items;
    int         kind;
    int         n_pay;
    int         n_noise;
    logic [7:0] cmd1;
    in_ch.valid       = 1'b0;
    in_ch.cmd_byte    = 8'h00;
    in_ch.frame_start = 1'b0;
    in_ch.module_addr = 8'h00;
    rst_n             = 1'b0;
    calm              = 1'b0;
    hold_off_req      = 1'b0;
    in_idle_pct       = 10;
    frame_items       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: a stray byte while idle is ignored.
    offer_byte(8'hFF, 1'b0, 8'hFF);
    // Empty payload with all-zero fields: eight bytes in one burst.
    offer_byte(8'h00, 1'b1, 8'h00);
    offer_byte(8'h00, 1'b0, 8'h00);
    // Upper bits of the second command byte set, and a payload byte equal to the tail.
    offer_byte(8'hFF, 1'b1, 8'hFF);
    offer_byte(8'hF1, 1'b0, 8'h00);
    offer_byte(8'hF0, 1'b0, 8'hFF);
    // Byte after a completed frame is ignored.
    offer_byte(8'h5A, 1'b0, 8'h12);
    // Restart while waiting for the second byte, then again during the payload.
    offer_byte(8'h11, 1'b1, 8'h22);
    offer_byte(8'h33, 1'b1, 8'h44);
    offer_byte(8'h03, 1'b0, 8'h99);
    offer_byte(8'hA5, 1'b0, 8'h00);
    offer_byte(8'h66, 1'b1, 8'h77);
    offer_byte(8'h10, 1'b0, 8'h00);
    // A short complete frame with two payload bytes.
    offer_byte(8'h80, 1'b1, 8'h80);
    offer_byte(8'h02, 1'b0, 8'h01);
    offer_byte(8'h7F, 1'b0, 8'hFE);
    offer_byte(8'h01, 1'b0, 8'h00);

    // Random part: the receiver holds off at once while the sender keeps going.
    hold_off_req = 1'b1;
    in_idle_pct  = 0;
    while (frame_items < FRAME_ITEMS) begin
      if (frame_items >= 40) begin
        case ($urandom_range(0, 2))
          0:       in_idle_pct = 0;
          1:       in_idle_pct = 15;
          default: in_idle_pct = 40;
        endcase
      end
      if (frame_items >= CALM_ITEMS) calm = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // Noise: bytes with no frame start.
        n_noise = $urandom_range(1, 3);
        repeat (n_noise) offer_byte(8'($urandom), 1'b0, 8'($urandom));
      end else begin
        offer_byte(8'($urandom), 1'b1, 8'($urandom));
        frame_items++;
        if (kind >= 12) begin
          cmd1 = 8'($urandom);
          offer_byte(cmd1, 1'b0, 8'($urandom));
          frame_items++;
          n_pay = int'(cmd1[3:0]);
          // Some frames are cut short by the next frame start.
          if (kind < 20 && n_pay > 0) n_pay = int'($urandom_range(0, n_pay - 1));
          repeat (n_pay) begin
            offer_byte(8'($urandom), 1'b0, 8'($urandom));
            frame_items++;
          end
        end
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait for every predicted byte, then let the pipeline settle.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("command_frame_packer verification clean");
    end else begin
      $display("command_frame_packer verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_if.sv
hw/rtl/cfp_front.sv
hw/rtl/cfp_job_fifo.sv
hw/rtl/cfp_back.sv
hw/rtl/command_frame_packer.sv
tb/cfp_frame_checker.sv
tb/testbench.sv
